// ===== hdl/scw_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the cutoff weight block.
// Used by scw_cordic_cell and smooth_cosine_cutoff_weight; no dependencies.
`default_nettype none
package scw_pkg;

  localparam logic [29:0] PiQ28       = 30'd843314857;
  localparam logic [29:0] HalfPiQ28   = 30'd421657428;
  localparam logic [31:0] GainInvQ28  = 32'd163008219;
  localparam logic signed [29:0] OneQ28 = 30'sd268435456;

  localparam logic [1:0] RegRc   = 2'd0;
  localparam logic [1:0] RegW    = 2'd1;
  localparam logic [1:0] RegPov  = 2'd2;
  localparam logic [1:0] RegMode = 2'd3;

  typedef struct packed {
    logic                band;
    logic                outside;
    logic signed [24:0]  dx;
    logic signed [24:0]  dy;
    logic signed [24:0]  dz;
  } side_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd210828714;
      1:  v = 32'd124459457;
      2:  v = 32'd65760959;
      3:  v = 32'd33381290;
      4:  v = 32'd16755422;
      5:  v = 32'd8385879;
      6:  v = 32'd4193963;
      7:  v = 32'd2097109;
      8:  v = 32'd1048571;
      9:  v = 32'd524287;
      10: v = 32'd262144;
      default: v = 32'd268435456 >> i;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/scw_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on scw_pkg for the angle table and the side-band word type.
`default_nettype none
module scw_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 vin,
  input  scw_pkg::side_t      sin_side,
  input  wire signed [31:0]   xin,
  input  wire signed [31:0]   yin,
  input  wire signed [31:0]   zin,
  output logic                vout,
  output scw_pkg::side_t      sout_side,
  output logic signed [31:0]  xout,
  output logic signed [31:0]  yout,
  output logic signed [31:0]  zout
);

  localparam logic signed [31:0] Ang = scw_pkg::atan_entry(IDX);

  logic signed [31:0] dx, dy;
  assign dx = yin >>> IDX;
  assign dy = xin >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sout_side <= sin_side;
      if (!zin[31]) begin
        xout <= xin - dx;
        yout <= yin + dy;
        zout <= zin - Ang;
      end else begin
        xout <= xin + dx;
        yout <= yin - dy;
        zout <= zin + Ang;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smooth_cosine_cutoff_weight.sv =====
// Shifted-cosine cutoff weight and gradient: front end, CORDIC chain, back end, APB regs.
// Depends on scw_pkg and scw_cordic_cell.
// An accepted word passes stage 0, stage 1, the CORDIC cells and both back-end registers; one word per cycle.
// The whole pipe advances together and stalls only when the output word is not taken.
// Synchronous reset empties the pipe and loads register defaults.
`default_nettype none
module smooth_cosine_cutoff_weight #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [3:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [23:0] distance,
  input  wire signed  [24:0] disp_x,
  input  wire signed  [24:0] disp_y,
  input  wire signed  [24:0] disp_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [17:0] weight,
  output logic               inside_res,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z
);

  logic [23:0] rc, wd;
  logic [31:0] pov;
  logic        mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc   <= 24'd262144;
      wd   <= 24'd32768;
      pov  <= 32'd105414357;
      mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        scw_pkg::RegRc:   rc   <= pwdata[23:0];
        scw_pkg::RegW:    wd   <= pwdata[23:0];
        scw_pkg::RegPov:  pov  <= pwdata;
        scw_pkg::RegMode: mode <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      scw_pkg::RegRc:   prdata = {8'd0, rc};
      scw_pkg::RegW:    prdata = {8'd0, wd};
      scw_pkg::RegPov:  prdata = pov;
      scw_pkg::RegMode: prdata = {31'd0, mode};
    endcase
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: classify, band offset
  logic signed [25:0] r_s, rc_s, w_s, lim, t_full;
  logic               outside0, band0;
  assign r_s      = $signed({2'b00, distance});
  assign rc_s     = $signed({2'b00, rc});
  assign w_s      = $signed({2'b00, wd});
  assign lim      = rc_s - w_s;
  assign t_full   = r_s - lim;
  assign outside0 = r_s > rc_s;
  assign band0    = !outside0 && !mode && !(r_s <= lim);

  logic           v0;
  scw_pkg::side_t side0;
  logic [23:0]    t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= '{band: band0, outside: outside0, dx: disp_x, dy: disp_y, dz: disp_z};
      t0    <= t_full[23:0];
    end
  end

  // stage 1: phase and CORDIC start angle
  logic [55:0] tp;
  logic [44:0] ph_full;
  logic [29:0] ph;
  assign tp      = 56'(t0) * 56'(pov);
  assign ph_full = 45'((tp + 56'd2048) >> 12);
  assign ph      = (ph_full > 45'(scw_pkg::PiQ28)) ? scw_pkg::PiQ28 : ph_full[29:0];

  localparam int N = CORDIC_STAGES;

  logic                v_s    [0:N];
  scw_pkg::side_t      side_s [0:N];
  logic signed [31:0]  x_s    [0:N];
  logic signed [31:0]  y_s    [0:N];
  logic signed [31:0]  z_s    [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0] <= side0;
      x_s[0]    <= $signed(scw_pkg::GainInvQ28);
      y_s[0]    <= 32'sd0;
      z_s[0]    <= $signed({2'b00, ph}) - $signed({2'b00, scw_pkg::HalfPiQ28});
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    scw_cordic_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .vin       (v_s[i]),
      .sin_side  (side_s[i]),
      .xin       (x_s[i]),
      .yin       (y_s[i]),
      .zin       (z_s[i]),
      .vout      (v_s[i+1]),
      .sout_side (side_s[i+1]),
      .xout      (x_s[i+1]),
      .yout      (y_s[i+1]),
      .zout      (z_s[i+1])
    );
  end

  // back end 1: clamp, weight, gradient scale
  logic signed [31:0] ncy;
  logic signed [29:0] cosp, sinp;
  logic signed [30:0] wsum;
  logic signed [62:0] sp;
  logic signed [33:0] h_next;
  logic signed [17:0] wt_next;

  assign ncy  = -y_s[N];
  assign cosp = (ncy > 32'(scw_pkg::OneQ28)) ? scw_pkg::OneQ28 :
                (ncy < -32'(scw_pkg::OneQ28)) ? -scw_pkg::OneQ28 : ncy[29:0];
  assign sinp = (x_s[N] > 32'(scw_pkg::OneQ28)) ? scw_pkg::OneQ28 :
                (x_s[N] < -32'(scw_pkg::OneQ28)) ? -scw_pkg::OneQ28 : x_s[N][29:0];
  assign wsum = 31'(scw_pkg::OneQ28) + 31'(cosp) + 31'sd4096;
  assign sp   = 63'(sinp) * $signed({31'd0, pov});
  assign h_next = 34'((sp + 63'sd268435456) >>> 29);

  always_comb begin
    priority if (side_s[N].outside) begin
      wt_next = -18'sd1;
    end else if (!side_s[N].band) begin
      wt_next = 18'sd65536;
    end else begin
      wt_next = 18'(wsum >>> 13);
    end
  end

  logic               v_e;
  scw_pkg::side_t     side_e;
  logic signed [33:0] h_e;
  logic signed [17:0] wt_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else if (en) begin
      v_e <= v_s[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_e <= side_s[N];
      h_e    <= h_next;
      wt_e   <= wt_next;
    end
  end

  // back end 2: gradient components, saturate
  function automatic logic signed [31:0] grad_of(input logic signed [33:0] hv,
                                                 input logic signed [24:0] dv);
    logic signed [59:0] p;
    logic signed [35:0] q;
    p = (-60'(hv)) * 60'(dv);
    q = 36'((p + 60'sd8388608) >>> 24);
    if (q > 36'sd2147483647)       return 32'sh7fffffff;
    else if (q < -36'sd2147483648) return 32'sh80000000;
    else                           return q[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight     <= wt_e;
      inside_res <= !side_e.outside;
      if (side_e.band) begin
        grad_x <= grad_of(h_e, side_e.dx);
        grad_y <= grad_of(h_e, side_e.dy);
        grad_z <= grad_of(h_e, side_e.dz);
      end else begin
        grad_x <= 32'sd0;
        grad_y <= 32'sd0;
        grad_z <= 32'sd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for smooth_cosine_cutoff_weight: directed table, then random words.
// Needs scw_pkg and the RTL; a predictor in this file models weight, flag and gradient.
module tb_top;

  localparam int Stages = 16;
  localparam int Latency = Stages + 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [23:0] distance = '0;
  logic signed [24:0] disp_x = '0, disp_y = '0, disp_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [17:0] weight;
  logic inside_res;
  logic signed [31:0] grad_x, grad_y, grad_z;

  typedef struct packed {
    logic signed [17:0] wt;
    logic               ins;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
  } cutoff_res_t;

  typedef struct packed {
    logic [23:0]        r;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dz;
  } pair_t;

  cutoff_res_t pending_q[$];
  int errors = 0;
  bit hold_off = 1'b0;

  logic [23:0] rc_q = 24'd262144;
  logic [23:0] w_q = 24'd32768;
  logic [31:0] pov_q = 32'd105414357;
  logic mode_q = 1'b0;

  smooth_cosine_cutoff_weight #(.CORDIC_STAGES(Stages)) uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic cutoff_res_t cutoff_weight(pair_t p);
    cutoff_res_t res;
    longint r, rc, w, pov, t, phase, x, y, z, dxs, dys, ang, cosp, sinp, h, wt;
    longint d[3], g[3];
    r = p.r; rc = rc_q; w = w_q; pov = pov_q;
    d[0] = p.dx; d[1] = p.dy; d[2] = p.dz;
    g = '{0, 0, 0};
    if (r > rc) wt = -1;
    else if (mode_q || r <= rc - w) wt = 65536;
    else begin
      t = r - rc + w;
      phase = (t * pov + 2048) >>> 12;
      if (phase > longint'(scw_pkg::PiQ28)) phase = longint'(scw_pkg::PiQ28);
      x = longint'(scw_pkg::GainInvQ28); y = 0;
      z = phase - longint'(scw_pkg::HalfPiQ28);
      for (int i = 0; i < Stages && i < 30; i++) begin
        ang = (i < 11) ? longint'(scw_pkg::atan_entry(i)) : (longint'(1) << 28) >> i;
        dxs = floor_shr(y, i); dys = floor_shr(x, i);
        if (z >= 0) begin
          x -= dxs; y += dys; z -= ang;
        end else begin
          x += dxs; y -= dys; z += ang;
        end
      end
      cosp = clip(-y, -268435456, 268435456);
      sinp = clip(x, -268435456, 268435456);
      wt = (268435456 + cosp + 4096) >>> 13;
      h = floor_shr(sinp * pov + (longint'(1) << 28), 29);
      for (int k = 0; k < 3; k++)
        g[k] = clip(floor_shr(-h * d[k] + (longint'(1) << 23), 24),
                    -64'sd2147483648, 64'sd2147483647);
    end
    res.wt = wt[17:0];
    res.ins = (r <= rc);
    res.gx = g[0][31:0]; res.gy = g[1][31:0]; res.gz = g[2][31:0];
    return res;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      scw_pkg::RegRc:  rc_q = val[23:0];
      scw_pkg::RegW:   w_q = val[23:0];
      scw_pkg::RegPov: pov_q = val;
      default:         mode_q = val[0];
    endcase
  endtask

  task automatic set_cutoff(logic [23:0] rc, logic [23:0] w, logic [31:0] pov, logic md);
    reg_write(scw_pkg::RegRc, {8'd0, rc});
    reg_write(scw_pkg::RegW, {8'd0, w});
    reg_write(scw_pkg::RegPov, pov);
    reg_write(scw_pkg::RegMode, {31'd0, md});
  endtask

  task automatic send_pair(pair_t p);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    distance <= p.r; disp_x <= p.dx; disp_y <= p.dy; disp_z <= p.dz;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(cutoff_weight(p));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic signed [24:0] rand_disp();
    case ($urandom_range(0, 3))
      0: return 25'sh1000000;
      1: return 25'sh0FFFFFF;
      default: return 25'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    logic [24:0] lo;
    lo = (rc_q > w_q) ? {1'b0, rc_q - w_q} : 25'd0;
    case ($urandom_range(0, 9))
      0: p.r = 24'($urandom);
      1: p.r = rc_q + 24'($urandom_range(0, 3));
      2: p.r = lo[23:0];
      default: p.r = 24'(lo + 25'($urandom_range(0, w_q)));
    endcase
    p.dx = rand_disp(); p.dy = rand_disp(); p.dz = rand_disp();
    return p;
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready <= ~out_ready;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cutoff_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected word: weight %0d", weight);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (weight !== want.wt) begin
          $error("weight exp %0d got %0d", want.wt, weight); errors++;
        end
        if (inside_res !== want.ins) begin
          $error("inside_res exp %0d got %0d", want.ins, inside_res); errors++;
        end
        if (grad_x !== want.gx) begin
          $error("grad_x exp %0d got %0d", want.gx, grad_x); errors++;
        end
        if (grad_y !== want.gy) begin
          $error("grad_y exp %0d got %0d", want.gy, grad_y); errors++;
        end
        if (grad_z !== want.gz) begin
          $error("grad_z exp %0d got %0d", want.gz, grad_z); errors++;
        end
      end
    end
  end

  initial begin
    hold_off = 1'b1;
    @(posedge clk);
    while (!in_valid) @(posedge clk);
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  typedef struct {
    pair_t       p;
    bit          fixed;
    cutoff_res_t res;
  } row_t;

  row_t dir_tab[] = '{
    '{'{24'd0, 25'sd0, 25'sd0, 25'sd0}, 1'b1, '{18'sd65536, 1'b1, 0, 0, 0}},
    '{'{24'hFFFFFF, 25'sh1000000, 25'sh0FFFFFF, 25'sd1}, 1'b1,
      '{-18'sd1, 1'b0, 0, 0, 0}},
    '{'{24'd262144, 25'sh0FFFFFF, 25'sh1000000, -25'sd1}, 1'b0, '{0, 0, 0, 0, 0}},
    '{'{24'd262145, 25'sd65536, 25'sd65536, 25'sd65536}, 1'b1,
      '{-18'sd1, 1'b0, 0, 0, 0}},
    '{'{24'd229376, 25'sd65536, -25'sd65536, 25'sd0}, 1'b1,
      '{18'sd65536, 1'b1, 0, 0, 0}},
    '{'{24'd229377, 25'sd65536, -25'sd65536, 25'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
    '{'{24'd245760, 25'sh0FFFFFF, 25'sh1000000, 25'sd12345}, 1'b0, '{0, 0, 0, 0, 0}},
    '{'{24'd253952, -25'sd77777, 25'sd99999, 25'sh1555555}, 1'b0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    pair_t p;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_pair(dir_tab[i].p);
      if (dir_tab[i].fixed && pending_q[$] !== dir_tab[i].res) begin
        $error("table row %0d: predictor disagrees", i); errors++;
      end
    end
    drain();
    // heaviside, then degenerate widths, then one pair with zero cutoff radius
    set_cutoff(24'd262144, 24'd32768, 32'd105414357, 1'b1);
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
    drain();
    set_cutoff(24'd262144, 24'd0, 32'hFFFFFFFF, 1'b0);
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
    drain();
    set_cutoff(24'd65536, 24'hFFFFFF, 32'd0, 1'b0);
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
    drain();
    set_cutoff(24'd0, 24'd1, 32'd1, 1'b0);
    p = '{24'd0, 25'sd5, -25'sd5, 25'sd0};
    send_pair(p);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_cutoff(24'd262144, 24'd32768, 32'd105414357, 1'b0);
        1: set_cutoff(24'hFFFFFF, 24'hFFFFFF, 32'd3294199, 1'b0);
        2: set_cutoff(24'd1000000, 24'd4000, 32'hFFFFFFFF, 1'b0);
        3: set_cutoff(24'($urandom), 24'($urandom_range(1, 24'hFFFFFF)), $urandom, 1'b0);
        4: set_cutoff(24'd500000, 24'd100000, 32'd55000000, 1'b1);
        default: set_cutoff(24'd131072, 24'd65536, 32'd52707179, 1'b0);
      endcase
      n = 0;
      while (n < 330) begin
        send_pair(rand_pair());
        n++;
      end
      drain();
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
